FILE: rtl/scmt_pkg.sv
// ----------------------------------------------------------------------------
// scmt_pkg
// Shared types and constants for the serial command to MIDI translator:
// controller states, byte classes, message kinds and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scmt_pkg;

  // Number of note channels tracked (1..4)
  localparam int NOTE_CHANNELS = 4;
  // Held-note store depth and channel index width (fixed by the protocol)
  localparam int HELD_DEPTH = 4;
  localparam int CH_W       = 2;

  // Field widths
  localparam int BYTE_W = 7;
  localparam int STAT_W = 8;
  localparam int LEN_W  = 2;
  localparam int CMD_W  = 4;

  // Received byte codes
  localparam logic [BYTE_W-1:0] RX_VALUE_MAX = 7'h6F;
  localparam logic [BYTE_W-1:0] RX_CMD_BASE  = 7'h70;
  localparam logic [BYTE_W-1:0] RX_START     = 7'h7D;
  localparam logic [BYTE_W-1:0] RX_STOP      = 7'h7E;
  localparam logic [BYTE_W-1:0] RX_TICK      = 7'h7F;

  // MIDI status bytes and data constants
  localparam logic [STAT_W-1:0] MIDI_STOP    = 8'hFC;
  localparam logic [STAT_W-1:0] MIDI_START   = 8'hFA;
  localparam logic [3:0]        MIDI_NOTE_ON = 4'h9;
  localparam logic [3:0]        MIDI_NOTE_OFF= 4'h8;
  localparam logic [3:0]        MIDI_CTRL    = 4'hB;
  localparam logic [3:0]        MIDI_PGM     = 4'hC;
  localparam logic [BYTE_W-1:0] CC_ALL_OFF   = 7'd123;
  localparam logic [BYTE_W-1:0] CC_MAX_VAL   = 7'h7F;
  localparam logic [BYTE_W-1:0] NOTE_VEL     = 7'd100;

  // Message lengths
  localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

  // Command index ranges
  localparam logic [CMD_W-1:0] CMD_CC_LO  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CC_HI  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PGM_LO = 4'd8;
  localparam logic [CMD_W-1:0] CMD_PGM_HI = 4'd11;

  // Controller state
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_START,
    ST_STOP,
    ST_STOP_OFF,
    ST_STOP_CC,
    ST_NOTE_OFF,
    ST_NOTE_ON,
    ST_CC,
    ST_PGM
  } state_t;

  // Class of the latched received byte
  typedef enum logic [2:0] {
    CLS_VALUE,
    CLS_CMD,
    CLS_START,
    CLS_STOP,
    CLS_TICK
  } byte_cls_t;

  // Kind of message to build into the output register
  typedef enum logic [2:0] {
    MSG_START,
    MSG_STOP,
    MSG_OFF_CMD,
    MSG_ON_CMD,
    MSG_OFF_CNT,
    MSG_ALLOFF_CNT,
    MSG_CC,
    MSG_PGM
  } msg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_byte;
    logic arm;
    logic disarm;
    logic emit;
    msg_t msg;
    logic last;
    logic held_clr;
    logic held_set;
    logic use_cnt;
    logic ch_clr;
    logic ch_inc;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    byte_cls_t        cls;
    logic             pending;
    logic [CMD_W-1:0] cmd;
    logic             val_zero;
    logic             held_nz;
    logic             cnt_last;
    logic             slot_free;
  } dp_stat_t;

  // Controller number table, indexed by value bits 6..4 (index 7 clamps)
  function automatic logic [BYTE_W-1:0] cc_number(input logic [2:0] idx);
    logic [BYTE_W-1:0] num;
    case (idx)
      3'd0:    num = 7'd1;
      3'd1:    num = 7'd2;
      3'd2:    num = 7'd3;
      3'd3:    num = 7'd7;
      3'd4:    num = 7'd10;
      3'd5:    num = 7'd11;
      default: num = 7'd12;
    endcase
    return num;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/scmt_ctrl.sv
// ----------------------------------------------------------------------------
// scmt_ctrl
// Controller: sequences one received byte into zero to nine MIDI messages,
// driving the datapath by command and reading back its status.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_ctrl
  import scmt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_t state_r, state_nxt;
  logic   note_ok;
  logic   is_cc;
  logic   is_pgm;

  // Command range decode of the armed command
  always_comb begin
    note_ok = (stat_i.cmd < CMD_W'(NOTE_CHANNELS));
    is_cc   = stat_i.cmd inside {[CMD_CC_LO:CMD_CC_HI]};
    is_pgm  = stat_i.cmd inside {[CMD_PGM_LO:CMD_PGM_HI]};
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (stat_i.cls)
          CLS_START: state_nxt = ST_START;
          CLS_STOP:  state_nxt = ST_STOP;
          CLS_VALUE: begin
            if (!stat_i.pending) begin
              state_nxt = ST_IDLE;
            end else if (note_ok) begin
              state_nxt = (stat_i.val_zero || stat_i.held_nz) ? ST_NOTE_OFF : ST_NOTE_ON;
            end else if (is_cc) begin
              state_nxt = ST_CC;
            end else if (is_pgm) begin
              state_nxt = ST_PGM;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_START, ST_NOTE_ON, ST_CC, ST_PGM: begin
        if (stat_i.slot_free) state_nxt = ST_IDLE;
      end
      ST_STOP: begin
        if (stat_i.slot_free) state_nxt = ST_STOP_OFF;
      end
      ST_STOP_OFF: begin
        if (!stat_i.held_nz || stat_i.slot_free) state_nxt = ST_STOP_CC;
      end
      ST_STOP_CC: begin
        if (stat_i.slot_free) state_nxt = stat_i.cnt_last ? ST_IDLE : ST_STOP_OFF;
      end
      ST_NOTE_OFF: begin
        if (stat_i.slot_free) state_nxt = stat_i.val_zero ? ST_IDLE : ST_NOTE_ON;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd_o     = '0;
    cmd_o.msg = MSG_START;
    case (state_r)
      ST_IDLE: begin
        in_tready       = 1'b1;
        cmd_o.load_byte = in_tvalid;
      end
      ST_DECODE: begin
        cmd_o.arm    = (stat_i.cls == CLS_CMD);
        cmd_o.disarm = (stat_i.cls == CLS_VALUE) && stat_i.pending;
      end
      ST_START: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.msg  = MSG_START;
        cmd_o.last = 1'b1;
      end
      ST_STOP: begin
        cmd_o.emit   = stat_i.slot_free;
        cmd_o.msg    = MSG_STOP;
        cmd_o.ch_clr = stat_i.slot_free;
      end
      ST_STOP_OFF: begin
        cmd_o.use_cnt = 1'b1;
        cmd_o.emit    = stat_i.held_nz && stat_i.slot_free;
        cmd_o.msg     = MSG_OFF_CNT;
      end
      ST_STOP_CC: begin
        cmd_o.use_cnt = 1'b1;
        cmd_o.emit    = stat_i.slot_free;
        cmd_o.msg     = MSG_ALLOFF_CNT;
        cmd_o.last    = stat_i.cnt_last;
        cmd_o.ch_inc  = stat_i.slot_free;
      end
      ST_NOTE_OFF: begin
        cmd_o.emit     = stat_i.slot_free;
        cmd_o.msg      = MSG_OFF_CMD;
        cmd_o.last     = stat_i.val_zero;
        cmd_o.held_clr = stat_i.slot_free && stat_i.val_zero;
      end
      ST_NOTE_ON: begin
        cmd_o.emit     = stat_i.slot_free;
        cmd_o.msg      = MSG_ON_CMD;
        cmd_o.last     = 1'b1;
        cmd_o.held_set = stat_i.slot_free;
      end
      ST_CC: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.msg  = MSG_CC;
        cmd_o.last = 1'b1;
      end
      ST_PGM: begin
        cmd_o.emit = stat_i.slot_free;
        cmd_o.msg  = MSG_PGM;
        cmd_o.last = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // A transfer in is always followed by a decode cycle
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DECODE))
    else $error("accepted byte not decoded");

  // The stop walk ends only after the last channel
  a_stop_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STOP_CC && state_nxt == ST_IDLE) |-> stat_i.cnt_last)
    else $error("stop walk ended early");

  // Nothing is emitted while a byte is being taken
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd_o.emit)
    else $error("emit while idle");

endmodule

`default_nettype wire

FILE: rtl/scmt_dp.sv
// ----------------------------------------------------------------------------
// scmt_dp
// Datapath: received byte register, armed command, held-note store, stop
// channel counter and the output message register.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_dp
  import scmt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_stat_t               stat_o,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [STAT_W-1:0]      status_byte_o,
  output logic [BYTE_W-1:0]      data_one_o,
  output logic [BYTE_W-1:0]      data_two_o,
  output logic [LEN_W-1:0]       msg_length_o,
  output logic                   last_o
);

  logic [BYTE_W-1:0] byte_r;
  logic              pend_r;
  logic [CMD_W-1:0]  pcmd_r;
  logic [BYTE_W-1:0] held_r [HELD_DEPTH];
  logic [CH_W-1:0]   ch_r;
  logic [CH_W-1:0]   ch_sel;
  logic [BYTE_W-1:0] held_sel;

  logic              ovalid_r;
  logic [STAT_W-1:0] ostat_r,  ostat_nxt;
  logic [BYTE_W-1:0] od1_r,    od1_nxt;
  logic [BYTE_W-1:0] od2_r,    od2_nxt;
  logic [LEN_W-1:0]  olen_r,   olen_nxt;
  logic              olast_r;
  logic              slot_free;
  byte_cls_t         cls;

  // Byte class
  always_comb begin
    if (byte_r <= RX_VALUE_MAX) begin
      cls = CLS_VALUE;
    end else if (byte_r == RX_TICK) begin
      cls = CLS_TICK;
    end else if (byte_r == RX_STOP) begin
      cls = CLS_STOP;
    end else if (byte_r == RX_START) begin
      cls = CLS_START;
    end else begin
      cls = CLS_CMD;
    end
  end

  // Single read port on the held-note store
  assign ch_sel   = cmd_i.use_cnt ? ch_r : pcmd_r[CH_W-1:0];
  assign held_sel = held_r[ch_sel];
  assign slot_free = !ovalid_r || out_tready;

  // Status back to the controller
  always_comb begin
    stat_o.cls       = cls;
    stat_o.pending   = pend_r;
    stat_o.cmd       = pcmd_r;
    stat_o.val_zero  = (byte_r == '0);
    stat_o.held_nz   = (held_sel != '0);
    stat_o.cnt_last  = (ch_r == CH_W'(NOTE_CHANNELS - 1));
    stat_o.slot_free = slot_free;
  end

  // Received byte
  always_ff @(posedge clk) begin
    if (cmd_i.load_byte) byte_r <= rx_byte_i;
  end

  // Armed command and stop channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      pcmd_r <= '0;
      ch_r   <= '0;
    end else begin
      if (cmd_i.arm) begin
        pend_r <= 1'b1;
        pcmd_r <= CMD_W'(byte_r - RX_CMD_BASE);
      end else if (cmd_i.disarm) begin
        pend_r <= 1'b0;
      end
      if (cmd_i.ch_clr) begin
        ch_r <= '0;
      end else if (cmd_i.ch_inc) begin
        ch_r <= ch_r + 1'b1;
      end
    end
  end

  // Held notes, one per channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HELD_DEPTH; i++) held_r[i] <= '0;
    end else if (cmd_i.held_clr) begin
      held_r[pcmd_r[CH_W-1:0]] <= '0;
    end else if (cmd_i.held_set) begin
      held_r[pcmd_r[CH_W-1:0]] <= byte_r;
    end
  end

  // Message build
  always_comb begin
    ostat_nxt = MIDI_START;
    od1_nxt   = '0;
    od2_nxt   = '0;
    olen_nxt  = LEN_ONE;
    case (cmd_i.msg)
      MSG_START: begin
        ostat_nxt = MIDI_START;
      end
      MSG_STOP: begin
        ostat_nxt = MIDI_STOP;
      end
      MSG_OFF_CMD, MSG_OFF_CNT: begin
        ostat_nxt = {MIDI_NOTE_OFF, 2'b00, ch_sel};
        od1_nxt   = held_sel;
        od2_nxt   = NOTE_VEL;
        olen_nxt  = LEN_THREE;
      end
      MSG_ON_CMD: begin
        ostat_nxt = {MIDI_NOTE_ON, 2'b00, ch_sel};
        od1_nxt   = byte_r;
        od2_nxt   = NOTE_VEL;
        olen_nxt  = LEN_THREE;
      end
      MSG_ALLOFF_CNT: begin
        ostat_nxt = {MIDI_CTRL, 2'b00, ch_sel};
        od1_nxt   = CC_ALL_OFF;
        od2_nxt   = CC_MAX_VAL;
        olen_nxt  = LEN_THREE;
      end
      MSG_CC: begin
        ostat_nxt = {MIDI_CTRL, 2'b00, pcmd_r[1:0]};
        od1_nxt   = cc_number(byte_r[6:4]);
        od2_nxt   = {byte_r[3:0], 3'b000};
        olen_nxt  = LEN_THREE;
      end
      MSG_PGM: begin
        ostat_nxt = {MIDI_PGM, 2'b00, pcmd_r[1:0]};
        od1_nxt   = byte_r;
        olen_nxt  = LEN_TWO;
      end
      default: begin
        ostat_nxt = MIDI_START;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      ostat_r <= ostat_nxt;
      od1_r   <= od1_nxt;
      od2_r   <= od2_nxt;
      olen_r  <= olen_nxt;
      olast_r <= cmd_i.last;
    end
  end

  assign out_tvalid    = ovalid_r;
  assign status_byte_o = ostat_r;
  assign data_one_o    = od1_r;
  assign data_two_o    = od2_r;
  assign msg_length_o  = olen_r;
  assign last_o        = olast_r;

  // A message is only built into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> (!ovalid_r || out_tready))
    else $error("output register overwritten");

  // A presented message carries a MIDI status byte and a sane length
  a_out_sane: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (ostat_r[STAT_W-1] && olen_r != '0))
    else $error("malformed message");

  // Stop walk reads only the tracked channels
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.use_cnt |-> ({1'b0, ch_r} < (CH_W + 1)'(NOTE_CHANNELS)))
    else $error("stop channel out of range");

endmodule

`default_nettype wire

FILE: rtl/serial_command_to_midi_translator_core.sv
// ----------------------------------------------------------------------------
// serial_command_to_midi_translator_core
// Turns 7-bit bytes from a serial command link into MIDI messages.
//
// Input stream: one byte per transfer (in_tdata[6:0]). Output stream: one
// MIDI message per transfer, out_tlast on the final message a byte causes.
// A byte is taken only while the controller is idle; the output register
// lets the next byte be taken while the last message still waits.
// A byte with no output (command arm, tick, stray value) passes through
// the idle and decode states only; a byte with messages then passes a
// state for each message. Stop walks STOP_OFF and STOP_CC per channel,
// at most one message per cycle, paced by the single output register.
// Reset clears the armed command and all held notes; no message is shown.
// When the receiver stalls, the message in the output register holds and
// the controller waits on the next message until the register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_to_midi_translator_core
  import scmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [6:0] rx_byte, [7] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] status_byte, [14:8] data_one,
                                       // [21:15] data_two, [23:22] msg_length
  output logic             out_tlast   // last_of_run
);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [STAT_W-1:0] status_byte;
  logic [BYTE_W-1:0] data_one;
  logic [BYTE_W-1:0] data_two;
  logic [LEN_W-1:0]  msg_length;

  // Sequencer
  scmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Byte, note state and message register
  scmt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte_i     (in_tdata[BYTE_W-1:0]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .status_byte_o (status_byte),
    .data_one_o    (data_one),
    .data_two_o    (data_two),
    .msg_length_o  (msg_length),
    .last_o        (out_tlast)
  );

  // Pack the message fields, lowest field first
  assign out_tdata = {msg_length, data_two, data_one, status_byte};

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_command_to_midi_translator_core. A queue of
// received bytes (directed cases, then mostly command/value pairs with random
// content) feeds a stream driver. Each accepted byte runs through a local
// translator model that queues the MIDI messages it should cause, and the
// output monitor checks every message transfer field by field. Both sides
// idle in random bursts until the tail of the run.
// ----------------------------------------------------------------------------

module tb;
  import scmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Bench constants
  localparam int                LIMIT_CYCLES = 200000;
  localparam int                TAIL_ITEMS   = 40;
  localparam int                RANDOM_ITEMS = 170;
  localparam int                MAX_REPORTS  = 10;
  localparam logic [BYTE_W-1:0] CMD_BASE     = 7'h70;
  localparam logic [CMD_W-1:0]  CMD_NOTE_HI  = 4'd3;
  localparam logic [CMD_W-1:0]  CMD_SPARE    = 4'd12;

  // One MIDI message as seen on the output stream
  typedef struct packed {
    logic [STAT_W-1:0] status_byte;
    logic [BYTE_W-1:0] data_one;
    logic [BYTE_W-1:0] data_two;
    logic [LEN_W-1:0]  msg_length;
    logic              last_of_run;
  } midi_msg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // Byte stream to send and messages still owed by the block
  logic [BYTE_W-1:0] rx_q[$];
  midi_msg_t         due_q[$];

  // Translator model state
  logic              armed;
  logic [CMD_W-1:0]  armed_cmd;
  logic [BYTE_W-1:0] held_notes [HELD_DEPTH];
  logic [BYTE_W-1:0] cc_numbers [7] = '{7'd1, 7'd2, 7'd3, 7'd7, 7'd10, 7'd11, 7'd12};

  int n_total;
  int n_accepted;
  int n_checked;
  int n_errors;
  int n_stops;
  int n_cycles;
  int src_gap;
  int src_calm;
  int sink_gap;
  int sink_calm;

  serial_command_to_midi_translator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // No idling once the stimulus is nearly used up
  function automatic bit tail_phase();
    return rx_q.size() < TAIL_ITEMS;
  endfunction

  function automatic midi_msg_t mk_msg(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] d1,
                                       logic [BYTE_W-1:0] d2, logic [LEN_W-1:0] len);
    midi_msg_t m;
    m.status_byte = st;
    m.data_one    = d1;
    m.data_two    = d2;
    m.msg_length  = len;
    m.last_of_run = 1'b0;
    return m;
  endfunction

  // Translate one received byte into the MIDI messages it causes
  function automatic void translate_byte(logic [BYTE_W-1:0] rx);
    midi_msg_t        run[$];
    logic [CMD_W-1:0] cmd;
    logic [2:0]       idx;
    if (rx > RX_VALUE_MAX) begin
      if (rx == RX_STOP) begin
        n_stops++;
        run = {run, mk_msg(MIDI_STOP, '0, '0, LEN_ONE)};
        for (int ch = 0; ch < NOTE_CHANNELS; ch++) begin
          if (held_notes[ch] != '0)
            run = {run, mk_msg({MIDI_NOTE_OFF, 4'(ch)}, held_notes[ch], NOTE_VEL,
                               LEN_THREE)};
          run = {run, mk_msg({MIDI_CTRL, 4'(ch)}, CC_ALL_OFF, CC_MAX_VAL, LEN_THREE)};
        end
      end else if (rx == RX_START) begin
        run = {run, mk_msg(MIDI_START, '0, '0, LEN_ONE)};
      end else if (rx != RX_TICK) begin
        armed_cmd = CMD_W'(rx - CMD_BASE);
        armed     = 1'b1;
      end
    end else if (armed) begin
      cmd   = armed_cmd;
      armed = 1'b0;
      if (cmd <= CMD_NOTE_HI) begin
        if (int'(cmd) < NOTE_CHANNELS) begin
          if (rx == '0) begin
            run = {run, mk_msg({MIDI_NOTE_OFF, cmd}, held_notes[cmd], NOTE_VEL,
                               LEN_THREE)};
            held_notes[cmd] = '0;
          end else begin
            if (held_notes[cmd] != '0)
              run = {run, mk_msg({MIDI_NOTE_OFF, cmd}, held_notes[cmd], NOTE_VEL,
                                 LEN_THREE)};
            run = {run, mk_msg({MIDI_NOTE_ON, cmd}, rx, NOTE_VEL, LEN_THREE)};
            held_notes[cmd] = rx;
          end
        end
      end else if (cmd <= CMD_CC_HI) begin
        idx = rx[6:4];
        if (idx > 3'd6) idx = 3'd6;
        run = {run, mk_msg({MIDI_CTRL, 4'(cmd - CMD_CC_LO)}, cc_numbers[idx],
                           {rx[3:0], 3'b000}, LEN_THREE)};
      end else if (cmd <= CMD_PGM_HI) begin
        run = {run, mk_msg({MIDI_PGM, 4'(cmd - CMD_PGM_LO)}, rx, '0, LEN_TWO)};
      end
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    due_q = {due_q, run};
  endfunction

  function automatic void add_pair(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] val);
    rx_q = {rx_q, CMD_BASE + BYTE_W'(cmd)};
    rx_q = {rx_q, val};
  endfunction

  // Input driver: one byte per transfer, idle bursts between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        translate_byte(in_tdata[6:0]);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_calm > 0) src_calm--;
        else if ($urandom_range(0, 24) == 0) src_calm = $urandom_range(10, 40);
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (rx_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!tail_phase() && src_calm == 0 && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, rx_q.pop_front()};
        end
      end
    end
  end

  // Output monitor: check each message transfer, stall in bursts
  always @(posedge clk) begin : mon
    midi_msg_t got;
    midi_msg_t exp_msg;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status_byte = out_tdata[7:0];
        got.data_one    = out_tdata[14:8];
        got.data_two    = out_tdata[21:15];
        got.msg_length  = out_tdata[23:22];
        got.last_of_run = out_tlast;
        n_checked++;
        if (due_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected message: status %h data %h %h len %0d last %0d",
                     got.status_byte, got.data_one, got.data_two, got.msg_length,
                     got.last_of_run);
        end else begin
          exp_msg = due_q.pop_front();
          if (got.status_byte != exp_msg.status_byte || got.data_one != exp_msg.data_one ||
              got.data_two != exp_msg.data_two || got.msg_length != exp_msg.msg_length ||
              got.last_of_run != exp_msg.last_of_run) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("message %0d: expected %h %h %h len %0d last %0d,",
                       n_checked, exp_msg.status_byte, exp_msg.data_one,
                       exp_msg.data_two, exp_msg.msg_length, exp_msg.last_of_run,
                       " got %h %h %h len %0d last %0d", got.status_byte,
                       got.data_one, got.data_two, got.msg_length, got.last_of_run);
          end
        end
      end
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 24) == 0) sink_calm = $urandom_range(10, 40);
      if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (!tail_phase() && sink_calm == 0 && $urandom_range(0, 4) == 0) begin
        sink_gap = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d bytes taken", n_cycles, n_accepted,
               n_total);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stim
    int r;
    int n_rand;
    logic [CMD_W-1:0] cmd;
    logic [BYTE_W-1:0] val;

    armed     = 1'b0;
    armed_cmd = '0;
    foreach (held_notes[i]) held_notes[i] = '0;

    // Directed: tick, stray value, start, note tracking, stop with held notes,
    // controller and program extremes, the spare command, rearming
    rx_q = {rx_q, RX_TICK};
    rx_q = {rx_q, RX_VALUE_MAX};
    rx_q = {rx_q, RX_START};
    add_pair(4'd0, 7'h3C);
    add_pair(4'd0, 7'h40);
    add_pair(4'd0, 7'h00);
    add_pair(4'd0, 7'h00);
    add_pair(CMD_NOTE_HI, RX_VALUE_MAX);
    add_pair(4'd1, 7'h01);
    rx_q = {rx_q, RX_STOP};
    add_pair(CMD_CC_LO, 7'h00);
    add_pair(CMD_CC_HI, RX_VALUE_MAX);
    add_pair(CMD_PGM_HI, 7'h55);
    add_pair(CMD_SPARE, 7'h2A);
    rx_q = {rx_q, CMD_BASE + BYTE_W'(CMD_PGM_LO)};
    rx_q = {rx_q, CMD_BASE + BYTE_W'(CMD_CC_LO + 4'd1)};
    rx_q = {rx_q, RX_START};
    rx_q = {rx_q, RX_TICK};
    rx_q = {rx_q, 7'h5B};

    // Random: mostly command/value pairs, plus transport bytes and noise
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r = $urandom_range(0, 99);
        if (r < 50) cmd = 4'($urandom_range(0, CMD_NOTE_HI));
        else if (r < 70) cmd = 4'($urandom_range(CMD_CC_LO, CMD_CC_HI));
        else if (r < 90) cmd = 4'($urandom_range(CMD_PGM_LO, CMD_PGM_HI));
        else cmd = CMD_SPARE;
        if (cmd <= CMD_NOTE_HI && $urandom_range(0, 6) == 0) val = '0;
        else val = 7'($urandom_range(0, RX_VALUE_MAX));
        add_pair(cmd, val);
        n_rand += 2;
      end else if (r < 68) begin
        rx_q = {rx_q, RX_STOP};
        n_rand++;
      end else if (r < 74) begin
        rx_q = {rx_q, RX_START};
        n_rand++;
      end else if (r < 79) begin
        rx_q = {rx_q, RX_TICK};
        n_rand++;
      end else if (r < 86) begin
        rx_q = {rx_q, 7'($urandom_range(0, RX_VALUE_MAX))};
        n_rand++;
      end else if (r < 93) begin
        rx_q = {rx_q, CMD_BASE + 7'($urandom_range(0, CMD_SPARE))};
        n_rand++;
      end else begin
        rx_q = {rx_q, 7'($urandom_range(0, 127))};
        n_rand++;
      end
    end
    n_total = rx_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || due_q.size() != 0) @(negedge clk);
    // let the longest run (stop with every note held) drain fully
    repeat (40) @(negedge clk);

    if (due_q.size() != 0) begin
      n_errors++;
      $display("%0d expected messages never arrived", due_q.size());
    end
    $display("sent %0d serial bytes (%0d stop sequences), checked %0d MIDI messages",
             n_accepted, n_stops, n_checked);
    $display("%0d mismatches in %0d cycles", n_errors, n_cycles);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
